/* hdl/tsw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants
// Request/result payloads, configuration view, queue and result records.
// ----------------------------------------------------------------------------
package tsw_pkg;

  // outstanding segment queue
  localparam int QUEUE_DEPTH = 32;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // results buffered per request
  localparam int MAX_RESULTS = 32;
  localparam int RIDX_W      = $clog2(MAX_RESULTS);
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam int ADDR_W = 4;

  // register reset values
  localparam logic [31:0] ISN_RST     = 32'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [10:0] MAXPL_RST   = 11'd1000;
  localparam logic [15:0] CAP_RST     = 16'd64000;

  typedef enum logic [1:0] {
    ACT_ACK   = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_EMPTY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_ISN     = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_MAXPL   = 2'd2,
    REG_CAP     = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_ACK_CHK,
    ST_POP_RD,
    ST_POP_CMP,
    ST_POP_END,
    ST_FILL,
    ST_TICK_A,
    ST_TICK_B,
    ST_STATUS,
    ST_REPLAY
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] ack_number;
    logic [15:0] peer_window;
    logic [15:0] elapsed_ms;
    logic [15:0] write_count;
    logic        write_ends;
  } req_t;

  typedef struct packed {
    logic        segment_valid;
    logic [31:0] seq_wrapped;
    logic [10:0] payload_bytes;
    logic        syn_flag;
    logic        fin_flag;
    logic        is_retransmit;
    logic        last_of_run;
    logic [16:0] in_flight_bytes;
    logic [15:0] retransmit_count;
  } res_t;

  typedef struct packed {
    logic [31:0] initial_seqno;
    logic [15:0] initial_timeout;
    logic [10:0] seg_max_len;
    logic [15:0] stream_capacity;
  } cfg_t;

  // queued segment descriptor
  typedef struct packed {
    logic [31:0] seq;
    logic [10:0] len;
    logic        syn;
    logic        fin;
  } seg_t;

  // buffered result record
  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [10:0] len;
    logic        syn;
    logic        fin;
    logic        retx;
  } rec_t;

endpackage

/* hdl/tsw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/tsw_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_cfg: configuration registers
// APB-style register file holding ISN, timeout, payload size and capacity.
// ----------------------------------------------------------------------------
module tsw_cfg import tsw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr;

  assign sel    = reg_e'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_ISN:     cfg_d.initial_seqno   = pwdata;
        REG_TIMEOUT: cfg_d.initial_timeout = pwdata[15:0];
        REG_MAXPL:   cfg_d.seg_max_len     = pwdata[10:0];
        REG_CAP:     cfg_d.stream_capacity = pwdata[15:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (sel)
      REG_ISN:     prdata = cfg_q.initial_seqno;
      REG_TIMEOUT: prdata = {16'd0, cfg_q.initial_timeout};
      REG_MAXPL:   prdata = {21'd0, cfg_q.seg_max_len};
      REG_CAP:     prdata = {16'd0, cfg_q.stream_capacity};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_seqno   <= ISN_RST;
      cfg_q.initial_timeout <= TIMEOUT_RST;
      cfg_q.seg_max_len     <= MAXPL_RST;
      cfg_q.stream_capacity <= CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hdl/tsw_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsw_core: sender sequencer
// Segment queue and result buffer in RAM; ack pop, fill, tick and replay.
// ----------------------------------------------------------------------------
module tsw_core import tsw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  state_e state_q, state_d;
  req_t   req_q, req_d;

  logic [63:0]       next_q, next_d;
  logic [16:0]       out_q, out_d;
  logic [15:0]       win_q, win_d;
  logic              syn_done_q, syn_done_d;
  logic              fin_done_q, fin_done_d;
  logic              timer_q, timer_d;
  logic [31:0]       elap_q, elap_d;
  logic [31:0]       cto_q, cto_d;
  logic [15:0]       retries_q, retries_d;
  logic [15:0]       buf_q, buf_d;
  logic              ended_q, ended_d;
  logic [QIDX_W-1:0] head_q, head_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]       abs_q, abs_d;
  logic [17:0]       diff_q, diff_d;
  logic              popped_q, popped_d;
  logic [RCNT_W-1:0] n_q, n_d;
  logic [RCNT_W-1:0] k_q, k_d;
  logic              pend_q, pend_d;
  logic [RIDX_W-1:0] pidx_q, pidx_d;

  // memory ports
  logic              q_we;
  logic [QIDX_W-1:0] q_waddr;
  seg_t              q_wdata, q_rdata;
  logic              r_we;
  logic [RIDX_W-1:0] r_waddr, r_raddr;
  rec_t              r_wdata, r_rdata;

  // fill datapath
  logic [16:0]       win, room0, room1, take, room2, buf_left, space;
  logic              syn_b, fin_b, empty, can_fill;
  logic [QIDX_W:0]   slot_sum;
  logic [QIDX_W-1:0] slot;
  // ack datapath
  logic [31:0]       ack_d;
  logic [63:0]       ack_s;
  logic [64:0]       ack_diff;
  logic [11:0]       seg_len;
  logic [18:0]       cov_sum;
  // misc
  logic [32:0]       elap_sum;
  logic [15:0]       wr_room, wr_add;
  logic              issue;

  tsw_ram #(.WIDTH($bits(seg_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  tsw_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_RESULTS)) u_results (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = pend_q;

  // result fields; counters hold their end-of-step values during replay
  always_comb begin
    res_o.segment_valid    = r_rdata.valid;
    res_o.seq_wrapped      = r_rdata.seq;
    res_o.payload_bytes    = r_rdata.len;
    res_o.syn_flag         = r_rdata.syn;
    res_o.fin_flag         = r_rdata.fin;
    res_o.is_retransmit    = r_rdata.retx;
    res_o.last_of_run      = ({1'b0, pidx_q} == (n_q - RCNT_W'(1)));
    res_o.in_flight_bytes  = out_q;
    res_o.retransmit_count = retries_q;
  end

  // segment builder for the next queued descriptor
  always_comb begin
    win      = (win_q == 16'd0) ? 17'd1 : {1'b0, win_q};
    syn_b    = ~syn_done_q;
    room0    = win - out_q;
    room1    = room0 - {16'd0, syn_b};
    take     = room1;
    if ({6'd0, cfg_i.seg_max_len} < take) take = {6'd0, cfg_i.seg_max_len};
    if ({1'b0, buf_q} < take) take = {1'b0, buf_q};
    room2    = room1 - take;
    buf_left = {1'b0, buf_q} - take;
    fin_b    = ~fin_done_q & ended_q & (buf_left == 17'd0) & (room2 != 17'd0);
    empty    = ~syn_b & ~fin_b & (take == 17'd0);
    space    = take + {16'd0, syn_b} + {16'd0, fin_b};
    can_fill = (n_q < RCNT_W'(MAX_RESULTS)) && (cnt_q < QCNT_W'(QUEUE_DEPTH))
               && (out_q < win);
    slot_sum = {1'b0, head_q} + (QIDX_W+1)'(cnt_q);
    if (slot_sum >= (QIDX_W+1)'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - (QIDX_W+1)'(QUEUE_DEPTH);
    end
    slot     = slot_sum[QIDX_W-1:0];
  end

  // ack unwrap and coverage test
  always_comb begin
    ack_d    = req_q.ack_number - (next_q[31:0] + cfg_i.initial_seqno);
    ack_s    = next_q + {32'd0, ack_d};
    ack_diff = {1'b0, next_q} - {1'b0, abs_q};
    seg_len  = {1'b0, q_rdata.len} + {11'd0, q_rdata.syn} + {11'd0, q_rdata.fin};
    cov_sum  = {7'd0, seg_len} + {1'b0, diff_q};
    elap_sum = {1'b0, elap_q} + {17'd0, req_q.elapsed_ms};
    wr_room  = (cfg_i.stream_capacity > buf_q) ? (cfg_i.stream_capacity - buf_q) : 16'd0;
    wr_add   = (req_i.write_count < wr_room) ? req_i.write_count : wr_room;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    next_d     = next_q;
    out_d      = out_q;
    win_d      = win_q;
    syn_done_d = syn_done_q;
    fin_done_d = fin_done_q;
    timer_d    = timer_q;
    elap_d     = elap_q;
    cto_d      = cto_q;
    retries_d  = retries_q;
    buf_d      = buf_q;
    ended_d    = ended_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    abs_d      = abs_q;
    diff_d     = diff_q;
    popped_d   = popped_q;
    n_d        = n_q;
    k_d        = k_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    q_we       = 1'b0;
    q_waddr    = slot;
    q_wdata    = '0;
    r_we       = 1'b0;
    r_waddr    = n_q[RIDX_W-1:0];
    r_wdata    = '0;
    r_raddr    = k_q[RIDX_W-1:0];
    issue      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          n_d   = '0;
          k_d   = '0;
          unique case (req_i.action)
            ACT_ACK:  state_d = ST_UNWRAP;
            ACT_TICK: state_d = ST_TICK_A;
            ACT_WRITE: begin
              if (!ended_q) begin
                buf_d = buf_q + wr_add;
                if (req_i.write_ends) ended_d = 1'b1;
              end
              state_d = ST_FILL;
            end
            ACT_EMPTY: begin
              r_we          = 1'b1;
              r_waddr       = '0;
              r_wdata.valid = 1'b1;
              r_wdata.seq   = next_q[31:0] + cfg_i.initial_seqno;
              n_d           = RCNT_W'(1);
              state_d       = ST_STATUS;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // absolute ack, tie resolves downward when it stays non-negative
      ST_UNWRAP: begin
        if (ack_d[31] && (ack_s[63:32] != 32'd0)) begin
          abs_d = {ack_s[63:32] - 32'd1, ack_s[31:0]};
        end else begin
          abs_d = ack_s;
        end
        state_d = ST_ACK_CHK;
      end

      // acks beyond the next seqno are dropped whole
      ST_ACK_CHK: begin
        if (ack_diff[64]) begin
          state_d = ST_STATUS;
        end else begin
          win_d    = req_q.peer_window;
          diff_d   = (ack_diff[63:17] != '0) ? 18'h20000 : {1'b0, ack_diff[16:0]};
          popped_d = 1'b0;
          state_d  = ST_POP_RD;
        end
      end

      ST_POP_RD: begin
        state_d = (cnt_q == '0) ? ST_POP_END : ST_POP_CMP;
      end

      // head segment is covered when start + len <= ack
      ST_POP_CMP: begin
        if (cov_sum > {2'b0, out_q}) begin
          state_d = ST_POP_END;
        end else begin
          out_d    = out_q - {5'd0, seg_len};
          head_d   = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIDX_W'(1);
          cnt_d    = cnt_q - QCNT_W'(1);
          popped_d = 1'b1;
          state_d  = ST_POP_RD;
        end
      end

      ST_POP_END: begin
        if (popped_q) begin
          retries_d = '0;
          cto_d     = {16'd0, cfg_i.initial_timeout};
          elap_d    = '0;
          timer_d   = (cnt_q != '0);
        end
        state_d = ST_FILL;
      end

      // one segment per cycle
      ST_FILL: begin
        if (!can_fill || empty) begin
          state_d = ST_STATUS;
        end else begin
          q_we          = 1'b1;
          q_wdata.seq   = next_q[31:0] + cfg_i.initial_seqno;
          q_wdata.len   = take[10:0];
          q_wdata.syn   = syn_b;
          q_wdata.fin   = fin_b;
          r_we          = 1'b1;
          r_wdata.valid = 1'b1;
          r_wdata.seq   = q_wdata.seq;
          r_wdata.len   = take[10:0];
          r_wdata.syn   = syn_b;
          r_wdata.fin   = fin_b;
          next_d        = next_q + {47'd0, space};
          buf_d         = buf_left[15:0];
          syn_done_d    = 1'b1;
          if (fin_b) fin_done_d = 1'b1;
          cnt_d         = cnt_q + QCNT_W'(1);
          out_d         = out_q + space;
          if (!timer_q) begin
            timer_d = 1'b1;
            elap_d  = '0;
            cto_d   = {16'd0, cfg_i.initial_timeout};
          end
          n_d = n_q + RCNT_W'(1);
          if (fin_b) state_d = ST_STATUS;
        end
      end

      ST_TICK_A: begin
        if (!timer_q || (cnt_q == '0)) begin
          state_d = ST_STATUS;
        end else begin
          elap_d  = elap_sum[32] ? 32'hFFFF_FFFF : elap_sum[31:0];
          state_d = ST_TICK_B;
        end
      end

      // expiry: resend head, back off unless window is zero
      ST_TICK_B: begin
        if (elap_q >= cto_q) begin
          r_we          = 1'b1;
          r_waddr       = '0;
          r_wdata.valid = 1'b1;
          r_wdata.seq   = q_rdata.seq;
          r_wdata.len   = q_rdata.len;
          r_wdata.syn   = q_rdata.syn;
          r_wdata.fin   = q_rdata.fin;
          r_wdata.retx  = 1'b1;
          n_d           = RCNT_W'(1);
          if (retries_q != 16'hFFFF) retries_d = retries_q + 16'd1;
          if (win_q != 16'd0) begin
            cto_d = cto_q[31] ? 32'hFFFF_FFFF : {cto_q[30:0], 1'b0};
          end
          elap_d = '0;
        end
        state_d = ST_STATUS;
      end

      // a step with no segment reports one status-only result
      ST_STATUS: begin
        if (n_q == '0) begin
          r_we    = 1'b1;
          r_waddr = '0;
          n_d     = RCNT_W'(1);
        end
        k_d     = '0;
        state_d = ST_REPLAY;
      end

      // stream buffered results out, one per cycle
      ST_REPLAY: begin
        issue  = (k_q < n_q);
        pend_d = issue;
        pidx_d = k_q[RIDX_W-1:0];
        if (issue) begin
          k_d = k_q + RCNT_W'(1);
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      next_q     <= '0;
      out_q      <= '0;
      win_q      <= 16'd1;
      syn_done_q <= 1'b0;
      fin_done_q <= 1'b0;
      timer_q    <= 1'b0;
      elap_q     <= '0;
      cto_q      <= {16'd0, TIMEOUT_RST};
      retries_q  <= '0;
      buf_q      <= '0;
      ended_q    <= 1'b0;
      head_q     <= '0;
      cnt_q      <= '0;
      popped_q   <= 1'b0;
      n_q        <= '0;
      k_q        <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      next_q     <= next_d;
      out_q      <= out_d;
      win_q      <= win_d;
      syn_done_q <= syn_done_d;
      fin_done_q <= fin_done_d;
      timer_q    <= timer_d;
      elap_q     <= elap_d;
      cto_q      <= cto_d;
      retries_q  <= retries_d;
      buf_q      <= buf_d;
      ended_q    <= ended_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      popped_q   <= popped_d;
      n_q        <= n_d;
      k_q        <= k_d;
      pend_q     <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    abs_q  <= abs_d;
    diff_q <= diff_d;
    pidx_q <= pidx_d;
  end

endmodule

/* hdl/tcp_sender_window_retransmit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_sender_window_retransmit: TCP sender window and retransmit timer
// A request (ack, tick, write, empty segment) is taken when start is high
// and busy is low; busy stays high until all its results are delivered.
// Results appear one per cycle on res_o with res_valid_o high for a single
// cycle each; the receiver cannot stall, last_of_run marks the final one.
// Every request gives one to 32 results; in_flight_bytes and
// retransmit_count on each are the values after the whole request.
// Steps: an ack is unwrapped and checked, then pops covered head segments
//   (a queue RAM read, then a compare, per pop), fills, and goes to status
//   and replay; a dropped ack goes straight to status. A tick checks the
//   timer, adds the elapsed time, then tests expiry; a write fills; an empty
//   segment request writes one result. A FIN ends the fill. The fill writes
//   one segment per cycle, and the result buffer is then replayed.
// Registers are to be written by the user through the APB port while busy
// is low; the block itself does not enforce it.
// Reset clears all counters; queue contents are not cleared and no entry is
// read before it is written.
// ----------------------------------------------------------------------------
module tcp_sender_window_retransmit import tsw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              res_valid_o,
  output res_t              res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;

  tsw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsw_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
